>>> hw/rtl/tmda_pkg.sv
// ----------------------------------------------------------------------------
// Trimmed-mean distance alarm package
// Shared widths, register indexes, reset values and state codes.
// ----------------------------------------------------------------------------
package tmda_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THR_MODE   = 3'd0,
        CFG_THR_LOWER  = 3'd1,
        CFG_THR_UPPER  = 3'd2,
        CFG_LONG_RANGE = 3'd3,
        CFG_ALERT_EN   = 3'd4,
        CFG_VALID_MIN  = 3'd5,
        CFG_SHORT_MAX  = 3'd6,
        CFG_LONG_MAX   = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_BELOW   = 2'd0,
        MODE_ABOVE   = 2'd1,
        MODE_INSIDE  = 2'd2,
        MODE_OUTSIDE = 2'd3
    } t_thr_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_TRIM,
        ST_DIV,
        ST_CHECK
    } t_state;

    localparam t_thr_mode           RST_THR_MODE   = MODE_BELOW;
    localparam logic [SAMPLE_W-1:0] RST_THR_LOWER  = 16'd100;
    localparam logic [SAMPLE_W-1:0] RST_THR_UPPER  = 16'd1000;
    localparam logic                RST_LONG_RANGE = 1'b0;
    localparam logic                RST_ALERT_EN   = 1'b1;
    localparam logic [SAMPLE_W-1:0] RST_VALID_MIN  = 16'd40;
    localparam logic [SAMPLE_W-1:0] RST_SHORT_MAX  = 16'd1300;
    localparam logic [SAMPLE_W-1:0] RST_LONG_MAX   = 16'd4000;

    // Below this many samples the window mean is not trimmed.
    localparam int TRIM_MIN_COUNT = 4;
    localparam int TRIM_DROP      = 2;

endpackage

>>> hw/rtl/tmda_if.sv
// ----------------------------------------------------------------------------
// Trimmed-mean distance alarm channels
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface tmda_sample_if import tmda_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_mm;

    modport source (output valid, output sample_mm, input ready);
    modport sink   (input valid, input sample_mm, output ready);
endinterface

interface tmda_result_if import tmda_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] mean_mm;
    logic                ready_res;
    logic                out_of_range;
    logic                alarm;

    modport source (output valid, output mean_mm, output ready_res,
                    output out_of_range, output alarm, input ready);
    modport sink   (input valid, input mean_mm, input ready_res,
                    input out_of_range, input alarm, output ready);
endinterface

interface tmda_cfg_if import tmda_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/tmda_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module tmda_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/tmda_divider.sv
// ----------------------------------------------------------------------------
// Serial unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tmda_divider #(
    parameter int DIVIDEND_W = 19,
    parameter int DIVISOR_W  = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_dvd;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;
    logic [DIVISOR_W:0]    trial;
    logic                  take;

    assign trial = {r_rem, r_dvd[DIVIDEND_W-1]};
    assign take  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIVIDEND_W);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // The dividend register shifts out its top bit and takes in the quotient bit.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy && (r_cnt != '0)) begin
            r_dvd <= {r_dvd[DIVIDEND_W-2:0], take};
            r_rem <= take ? DIVISOR_W'(trial - {1'b0, r_div}) : trial[DIVISOR_W-1:0];
        end
    end

    assign o_done     = r_busy && (r_cnt == '0);
    assign o_quotient = r_dvd;

endmodule

>>> hw/rtl/trimmed_mean_distance_alarm.sv
// ----------------------------------------------------------------------------
// Trimmed-mean distance alarm
// Keeps a ring of recent distance samples in RAM, reports their mean, trimmed from
// four samples on, and drives a threshold alarm once a sample finds the window full.
// ----------------------------------------------------------------------------
//  Channel    Direction  Payload                                   Handshake
//  i_sample   in         sample_mm                                 valid/ready
//  o_result   out        mean_mm, ready_res, out_of_range, alarm   valid/ready
//  i_cfg      in         index, data (register write)              valid/ready
//
//  An item with one stored sample goes straight to the check step. Otherwise
//  it walks over the stored samples through the RAM read port and then runs
//  a serial division of the sum; the default window holds 8 samples.
//  Synchronous active-low reset clears control state and loads the register
//  reset values. The ring needs no clearing: only written entries are read.
//  A stalled result holds the next one in the check step; the next sample is
//  accepted as soon as a result has moved into the output register.
// ----------------------------------------------------------------------------
module trimmed_mean_distance_alarm
    import tmda_pkg::*;
#(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tmda_sample_if.sink   i_sample,
    tmda_result_if.source o_result,
    tmda_cfg_if.sink      i_cfg
);

    localparam int ADDR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_DEPTH);

    // Configuration registers
    t_thr_mode           r_thr_mode;
    logic [SAMPLE_W-1:0] r_thr_lower;
    logic [SAMPLE_W-1:0] r_thr_upper;
    logic                r_long_range;
    logic                r_alert_en;
    logic [SAMPLE_W-1:0] r_valid_min;
    logic [SAMPLE_W-1:0] r_short_max;
    logic [SAMPLE_W-1:0] r_long_max;

    // Control and working state
    t_state              r_state;
    t_state              n_state;
    logic [ADDR_W-1:0]   r_wr_slot;
    logic [CNT_W-1:0]    r_fill;
    logic                r_ready_flag;
    logic                r_range_fault;
    logic                r_alarm_flag;
    logic [CNT_W-1:0]    r_rd_idx;
    logic                r_rd_vld;
    logic                r_first;
    logic [SUM_W-1:0]    r_sum;
    logic [SAMPLE_W-1:0] r_lo;
    logic [SAMPLE_W-1:0] r_hi;
    logic [SAMPLE_W-1:0] r_mean;

    // Output register
    logic                r_out_vld;
    logic [SAMPLE_W-1:0] r_out_mean;
    logic                r_out_ready;
    logic                r_out_range;
    logic                r_out_alarm;

    // Control strobes
    logic                in_fire;
    logic                rd_issue;
    logic                div_start;
    logic                out_load;

    logic [SAMPLE_W-1:0] ram_rdata;
    logic                div_done;
    logic [SUM_W-1:0]    div_quot;
    logic [SUM_W-1:0]    trim_sum;
    logic [CNT_W-1:0]    trim_div;

    logic [SAMPLE_W-1:0] range_limit;
    logic                range_bad;
    logic                thr_hit;
    logic                n_range_fault;
    logic                n_alarm_flag;

    assign i_cfg.ready = 1'b1;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_mode   <= RST_THR_MODE;
            r_thr_lower  <= RST_THR_LOWER;
            r_thr_upper  <= RST_THR_UPPER;
            r_long_range <= RST_LONG_RANGE;
            r_alert_en   <= RST_ALERT_EN;
            r_valid_min  <= RST_VALID_MIN;
            r_short_max  <= RST_SHORT_MAX;
            r_long_max   <= RST_LONG_MAX;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_THR_MODE:   r_thr_mode   <= t_thr_mode'(i_cfg.data[1:0]);
                CFG_THR_LOWER:  r_thr_lower  <= i_cfg.data[SAMPLE_W-1:0];
                CFG_THR_UPPER:  r_thr_upper  <= i_cfg.data[SAMPLE_W-1:0];
                CFG_LONG_RANGE: r_long_range <= i_cfg.data[0];
                CFG_ALERT_EN:   r_alert_en   <= i_cfg.data[0];
                CFG_VALID_MIN:  r_valid_min  <= i_cfg.data[SAMPLE_W-1:0];
                CFG_SHORT_MAX:  r_short_max  <= i_cfg.data[SAMPLE_W-1:0];
                CFG_LONG_MAX:   r_long_max   <= i_cfg.data[SAMPLE_W-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sample ring and divider
    // ------------------------------------------------------------------
    tmda_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_DEPTH),
        .ADDR_W(ADDR_W)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (in_fire),
        .i_waddr(r_wr_slot),
        .i_wdata(i_sample.sample_mm),
        .i_re   (rd_issue),
        .i_raddr(r_rd_idx[ADDR_W-1:0]),
        .o_rdata(ram_rdata)
    );

    // Drop one minimum and one maximum once the window holds enough samples.
    always_comb begin
        if (r_fill >= CNT_W'(TRIM_MIN_COUNT)) begin
            trim_sum = r_sum - SUM_W'(r_lo) - SUM_W'(r_hi);
            trim_div = r_fill - CNT_W'(TRIM_DROP);
        end else begin
            trim_sum = r_sum;
            trim_div = r_fill;
        end
    end

    tmda_divider #(
        .DIVIDEND_W(SUM_W),
        .DIVISOR_W (CNT_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(trim_sum),
        .i_divisor (trim_div),
        .o_done    (div_done),
        .o_quotient(div_quot)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = (r_fill == '0) ? ST_CHECK : ST_WALK;
                end
            end
            ST_WALK: begin
                if ((r_rd_idx == r_fill) && !r_rd_vld) begin
                    n_state = ST_TRIM;
                end
            end
            ST_TRIM: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        i_sample.ready = (r_state == ST_IDLE);
        rd_issue       = (r_state == ST_WALK) && (r_rd_idx < r_fill);
        div_start      = (r_state == ST_TRIM);
        out_load       = (r_state == ST_CHECK) && (!r_out_vld || o_result.ready);
    end

    assign in_fire = i_sample.valid && i_sample.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Window bookkeeping
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_slot    <= '0;
            r_fill       <= '0;
            r_ready_flag <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_rd_idx     <= '0;
        end else begin
            r_rd_vld <= rd_issue;
            if (in_fire) begin
                r_wr_slot <= (r_wr_slot == ADDR_W'(WINDOW_DEPTH - 1)) ? '0
                                                                    : r_wr_slot + 1'b1;
                if (r_fill < CNT_W'(WINDOW_DEPTH)) begin
                    r_fill <= r_fill + 1'b1;
                end else begin
                    r_ready_flag <= 1'b1;
                end
                r_rd_idx <= '0;
            end else if (rd_issue) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
        end
    end

    // Mean, and sum, minimum and maximum over stored samples, seeded by entry zero.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_first <= 1'b1;
            r_mean  <= i_sample.sample_mm;
        end else if (r_rd_vld) begin
            r_first <= 1'b0;
            if (r_first) begin
                r_sum <= SUM_W'(ram_rdata);
                r_lo  <= ram_rdata;
                r_hi  <= ram_rdata;
            end else begin
                r_sum <= r_sum + SUM_W'(ram_rdata);
                if (ram_rdata < r_lo) begin
                    r_lo <= ram_rdata;
                end
                if (ram_rdata > r_hi) begin
                    r_hi <= ram_rdata;
                end
            end
        end else if (div_done) begin
            r_mean <= div_quot[SAMPLE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Range and threshold check
    // ------------------------------------------------------------------
    always_comb begin
        range_limit = r_long_range ? r_long_max : r_short_max;
        range_bad   = (r_mean < r_valid_min) || (r_mean > range_limit);
        unique case (r_thr_mode)
            MODE_BELOW:   thr_hit = (r_mean < r_thr_lower);
            MODE_ABOVE:   thr_hit = (r_mean > r_thr_upper);
            MODE_INSIDE:  thr_hit = (r_mean > r_thr_lower) && (r_mean < r_thr_upper);
            MODE_OUTSIDE: thr_hit = (r_mean < r_thr_lower) || (r_mean > r_thr_upper);
        endcase
        n_range_fault = r_range_fault;
        n_alarm_flag  = r_alarm_flag;
        if (r_ready_flag) begin
            if (range_bad) begin
                n_range_fault = 1'b1;
                n_alarm_flag  = 1'b0;
            end else begin
                n_range_fault = 1'b0;
                if (!thr_hit) begin
                    n_alarm_flag = 1'b0;
                end else if (r_alert_en) begin
                    n_alarm_flag = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_fault <= 1'b0;
            r_alarm_flag  <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            if (out_load) begin
                r_range_fault <= n_range_fault;
                r_alarm_flag  <= n_alarm_flag;
                r_out_vld     <= 1'b1;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_mean  <= r_mean;
            r_out_ready <= r_ready_flag;
            r_out_range <= n_range_fault;
            r_out_alarm <= n_alarm_flag;
        end
    end

    assign o_result.valid        = r_out_vld;
    assign o_result.mean_mm      = r_out_mean;
    assign o_result.ready_res    = r_out_ready;
    assign o_result.out_of_range = r_out_range;
    assign o_result.alarm        = r_out_alarm;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= CNT_W'(WINDOW_DEPTH)) && (r_rd_idx <= r_fill))
        else $error("fill count or read index beyond the window");

    a_ready_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready_flag |=> r_ready_flag)
        else $error("ready flag dropped");

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready_flag |-> (r_fill == CNT_W'(WINDOW_DEPTH)))
        else $error("ready flag set before the window filled");

    a_fault_alarm_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out_range && r_out_alarm))
        else $error("range fault and alarm reported together");

endmodule
